// File: sv/assert_macros.svh
// Assertion macros shared by the RTL of the bitmap pixel unpacker.
// Expects a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset
`define BMP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included
`define BMP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: sv/bmp24_pkg.sv
// Shared types, constants and helpers for the 24-bit bitmap pixel unpacker.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package bmp24_pkg;

    // Field widths
    localparam int COORD_BITS = 16;
    localparam int DIM_BITS   = 12;
    localparam int COLOR_BITS = 24;
    localparam int BYTE_BITS  = 8;
    localparam int PADDR_W    = 5;
    localparam int PDATA_W    = 32;

    // Largest supported image dimension
    localparam logic [DIM_BITS-1:0] MAX_DIM = 12'd4095;

    // Register map, index = paddr[4:2]
    localparam logic [2:0] REG_ORIGIN_X     = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y     = 3'd1;
    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd2;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd3;
    localparam logic [2:0] REG_KEY_COLOR    = 3'd4;

    // Position of the next byte inside a blue, green, red triple
    localparam logic [1:0] PHASE_BLUE  = 2'd0;
    localparam logic [1:0] PHASE_GREEN = 2'd1;
    localparam logic [1:0] PHASE_RED   = 2'd2;

    // One result beat
    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
        logic [COLOR_BITS-1:0] pixel_color;
        logic                  visible;
        logic                  end_of_image;
    } t_pixel;

    // Zero counts as one, oversize clamps to MAX_DIM
    function automatic logic [DIM_BITS-1:0] eff_dim(input logic [DIM_BITS-1:0] v);
        logic [DIM_BITS-1:0] r;
        r = v;
        if (v == '0) begin
            r = DIM_BITS'(1);
        end else if (v > MAX_DIM) begin
            r = MAX_DIM;
        end
        return r;
    endfunction

endpackage

// File: sv/bmp24_in_if.sv
// Input channel of the bitmap pixel unpacker: one raw bitmap byte per beat.
// Depends on bmp24_pkg for the byte width.
`timescale 1ns / 1ps

interface bmp24_in_if import bmp24_pkg::*; ;
    logic                 valid;
    logic                 ready;
    logic [BYTE_BITS-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

// File: sv/bmp24_out_if.sv
// Output channel of the bitmap pixel unpacker: one pixel result per beat.
// Depends on bmp24_pkg for field widths.
`timescale 1ns / 1ps

interface bmp24_out_if import bmp24_pkg::*; ;
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [COLOR_BITS-1:0] pixel_color;
    logic                  visible;
    logic                  end_of_image;

    modport source (output valid, output pixel_x, output pixel_y, output pixel_color,
                    output visible, output end_of_image, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, input pixel_color,
                    input visible, input end_of_image, output ready);
endinterface

// File: sv/bmp24_pixel_stream_unpacker_top.sv
// Top level of the 24-bit bottom-up bitmap pixel unpacker.
// Depends on bmp24_pkg, bmp24_in_if, bmp24_out_if and assert_macros.svh.
//
//  channel  | direction | handshake       | beat
//  ---------+-----------+-----------------+-----------------------------------
//  i_pix    | in        | valid / ready   | data_byte: one bitmap byte
//  o_pix    | out       | valid / ready   | pixel_x, pixel_y, pixel_color,
//           |           |                 | visible, end_of_image
//  apb      | in        | psel / penable  | 32-bit register write or read
//
// One byte is taken per cycle while i_pix.ready is high; a result is built from
// its red byte in the input register, then held in the result register.
// Synchronous active-low reset clears counters, both valid flags and the
// registers (width and height to 1).
// i_pix.ready drops only while the input register and the result register are
// both full and o_pix.ready is low.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module bmp24_pixel_stream_unpacker_top import bmp24_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    bmp24_in_if.sink           i_pix,
    bmp24_out_if.source        o_pix,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    // Configuration registers
    logic [COORD_BITS-1:0] r_origin_x;
    logic [COORD_BITS-1:0] r_origin_y;
    logic [DIM_BITS-1:0]   r_image_width;
    logic [DIM_BITS-1:0]   r_image_height;
    logic [COLOR_BITS-1:0] r_key_color;

    // Pipeline registers
    logic                 r_in_valid;
    logic [BYTE_BITS-1:0] r_in_byte;
    logic                 r_out_valid;
    t_pixel               r_out;

    // Decode state
    logic [1:0]          r_byte_phase, n_byte_phase;
    logic [15:0]         r_partial_color, n_partial_color;
    logic [DIM_BITS-1:0] r_column_count, n_column_count;
    logic [DIM_BITS-1:0] r_row_count, n_row_count;
    logic [1:0]          r_pad_remaining, n_pad_remaining;
    logic                r_in_padding, n_in_padding;

    logic                  w_cfg_wr;
    logic                  w_advance;
    logic                  n_res_valid;
    t_pixel                n_out;
    logic [DIM_BITS-1:0]   w_eff_w;
    logic [DIM_BITS-1:0]   w_eff_h;
    logic [DIM_BITS:0]     w_col_inc;
    logic [DIM_BITS:0]     w_row_inc;
    logic                  w_last_col;
    logic                  w_last_row;
    logic [DIM_BITS-1:0]   w_row_next;
    logic [1:0]            w_pad_dec;
    logic [COLOR_BITS-1:0] w_color;

    // APB write and read
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x     <= '0;
            r_origin_y     <= '0;
            r_image_width  <= DIM_BITS'(1);
            r_image_height <= DIM_BITS'(1);
            r_key_color    <= '0;
        end else if (w_cfg_wr) begin
            unique case (paddr[4:2])
                REG_ORIGIN_X:     r_origin_x     <= pwdata[COORD_BITS-1:0];
                REG_ORIGIN_Y:     r_origin_y     <= pwdata[COORD_BITS-1:0];
                REG_IMAGE_WIDTH:  r_image_width  <= pwdata[DIM_BITS-1:0];
                REG_IMAGE_HEIGHT: r_image_height <= pwdata[DIM_BITS-1:0];
                REG_KEY_COLOR:    r_key_color    <= pwdata[COLOR_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_ORIGIN_X:     prdata = PDATA_W'(r_origin_x);
            REG_ORIGIN_Y:     prdata = PDATA_W'(r_origin_y);
            REG_IMAGE_WIDTH:  prdata = PDATA_W'(r_image_width);
            REG_IMAGE_HEIGHT: prdata = PDATA_W'(r_image_height);
            REG_KEY_COLOR:    prdata = PDATA_W'(r_key_color);
            default:          prdata = '0;
        endcase
    end

    // Input register: the held byte moves on whenever the result slot is free
    assign w_advance   = r_in_valid && (!r_out_valid || o_pix.ready);
    assign i_pix.ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_pix.ready) begin
            r_in_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pix.valid && i_pix.ready) begin
            r_in_byte <= i_pix.data_byte;
        end
    end

    // Row and column bookkeeping
    assign w_eff_w    = eff_dim(r_image_width);
    assign w_eff_h    = eff_dim(r_image_height);
    assign w_col_inc  = {1'b0, r_column_count} + (DIM_BITS+1)'(1);
    assign w_row_inc  = {1'b0, r_row_count} + (DIM_BITS+1)'(1);
    assign w_last_col = w_col_inc >= {1'b0, w_eff_w};
    assign w_last_row = w_row_inc >= {1'b0, w_eff_h};
    assign w_row_next = w_last_row ? '0 : w_row_inc[DIM_BITS-1:0];
    assign w_pad_dec  = r_pad_remaining - 2'd1;
    assign w_color    = {r_in_byte, r_partial_color};

    // Result fields for a completed pixel
    always_comb begin
        n_out.pixel_x      = r_origin_x + COORD_BITS'(r_column_count);
        n_out.pixel_y      = r_origin_y + COORD_BITS'(w_eff_h) - COORD_BITS'(r_row_count)
                             - COORD_BITS'(1);
        n_out.pixel_color  = w_color;
        n_out.visible      = w_color != r_key_color;
        n_out.end_of_image = w_last_col && w_last_row;
    end

    // Byte decode: padding skip, triple assembly, row wrap
    always_comb begin
        n_byte_phase    = r_byte_phase;
        n_partial_color = r_partial_color;
        n_column_count  = r_column_count;
        n_row_count     = r_row_count;
        n_pad_remaining = r_pad_remaining;
        n_in_padding    = r_in_padding;
        n_res_valid     = 1'b0;
        if (w_advance) begin
            if (r_in_padding) begin
                n_pad_remaining = w_pad_dec;
                if (w_pad_dec == 2'd0) begin
                    n_in_padding = 1'b0;
                    n_row_count  = w_row_next;
                end
            end else begin
                unique case (r_byte_phase)
                    PHASE_BLUE: begin
                        n_partial_color = {8'h00, r_in_byte};
                        n_byte_phase    = PHASE_GREEN;
                    end
                    PHASE_GREEN: begin
                        n_partial_color = {r_in_byte, r_partial_color[7:0]};
                        n_byte_phase    = PHASE_RED;
                    end
                    // red byte; an unused phase code behaves the same
                    default: begin
                        n_byte_phase = PHASE_BLUE;
                        n_res_valid  = n_out.visible || n_out.end_of_image;
                        if (w_last_col) begin
                            n_column_count = '0;
                            // padding length equals width mod 4
                            if (w_eff_w[1:0] != 2'd0) begin
                                n_pad_remaining = w_eff_w[1:0];
                                n_in_padding    = 1'b1;
                            end else begin
                                n_row_count = w_row_next;
                            end
                        end else begin
                            n_column_count = w_col_inc[DIM_BITS-1:0];
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_phase    <= PHASE_BLUE;
            r_partial_color <= '0;
            r_column_count  <= '0;
            r_row_count     <= '0;
            r_pad_remaining <= '0;
            r_in_padding    <= 1'b0;
        end else begin
            r_byte_phase    <= n_byte_phase;
            r_partial_color <= n_partial_color;
            r_column_count  <= n_column_count;
            r_row_count     <= n_row_count;
            r_pad_remaining <= n_pad_remaining;
            r_in_padding    <= n_in_padding;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && n_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_pix.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && n_res_valid) begin
            r_out <= n_out;
        end
    end

    assign o_pix.valid        = r_out_valid;
    assign o_pix.pixel_x      = r_out.pixel_x;
    assign o_pix.pixel_y      = r_out.pixel_y;
    assign o_pix.pixel_color  = r_out.pixel_color;
    assign o_pix.visible      = r_out.visible;
    assign o_pix.end_of_image = r_out.end_of_image;

    // Checks
    `BMP_ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> !r_out_valid && !r_in_valid, "valid flags not cleared by reset")
    `BMP_ASSERT(a_pad_count, r_in_padding |-> r_pad_remaining != 2'd0, "padding with zero bytes left")
    `BMP_ASSERT(a_pad_on_boundary, (r_byte_phase != PHASE_BLUE) |-> !r_in_padding, "padding inside a color triple")
    `BMP_ASSERT(a_result_kind, r_out_valid |-> (r_out.visible || r_out.end_of_image), "hidden pixel emitted mid-image")
    `BMP_ASSERT(a_eoi_wraps, (w_advance && n_res_valid && n_out.end_of_image) |=> (r_column_count == '0), "column not restarted after last pixel")

endmodule

// File: tb/bmp24_pixel_stream_unpacker_top_test.sv
// Self-checking testbench for the 24-bit bitmap pixel unpacker top level.
// Depends on bmp24_pkg, bmp24_in_if, bmp24_out_if and the unpacker RTL.
`timescale 1ns / 1ps

module bmp24_pixel_stream_unpacker_top_test import bmp24_pkg::*; ;

    localparam int SETTLE_CYCLES = 4;      // result register sits behind the input register
    localparam int HOLD_CYCLES   = 250;    // long receiver hold-off
    localparam int TARGET_BYTES  = 1400;

    // Tracks the decode state, predicts pixel beats and checks them in order
    class pixel_scoreboard;
        // register shadow
        logic [15:0] org_x;
        logic [15:0] org_y;
        logic [11:0] width_reg;
        logic [11:0] height_reg;
        logic [23:0] key;
        // decode state
        logic [1:0]  phase;
        logic [15:0] partial;
        logic [11:0] col;
        logic [11:0] row;
        logic [1:0]  pad_left;
        logic        in_pad;
        t_pixel      expected_q[$];
        int          errors;
        int          checked;
        int          hidden_finals;
        int          images_done;

        function new();
            org_x = '0;
            org_y = '0;
            width_reg = 12'd1;
            height_reg = 12'd1;
            key = '0;
            phase = PHASE_BLUE;
            partial = '0;
            col = '0;
            row = '0;
            pad_left = '0;
            in_pad = 1'b0;
            errors = 0;
            checked = 0;
            hidden_finals = 0;
            images_done = 0;
        endfunction

        function logic [11:0] clamp_dim(input logic [11:0] v);
            if (v == 12'd0) return 12'd1;
            if (v > MAX_DIM) return MAX_DIM;
            return v;
        endfunction

        function void set_reg(input logic [2:0] idx, input logic [31:0] v);
            case (idx)
                REG_ORIGIN_X:     org_x = v[15:0];
                REG_ORIGIN_Y:     org_y = v[15:0];
                REG_IMAGE_WIDTH:  width_reg = v[11:0];
                REG_IMAGE_HEIGHT: height_reg = v[11:0];
                REG_KEY_COLOR:    key = v[23:0];
                default: ;
            endcase
        endfunction

        function void advance_row();
            if (int'(row) + 1 >= int'(clamp_dim(height_reg))) row = '0;
            else row = row + 12'd1;
        endfunction

        // One accepted bitmap byte; queues a pixel beat when one is due
        function void note_byte(input logic [7:0] b);
            logic [11:0] w;
            logic [11:0] h;
            logic [13:0] row_bytes;
            logic [23:0] color;
            logic        last_col;
            logic        eoi;
            logic        vis;
            t_pixel      px;
            if (in_pad) begin
                pad_left = pad_left - 2'd1;
                if (pad_left == 2'd0) begin
                    in_pad = 1'b0;
                    advance_row();
                end
                return;
            end
            if (phase == PHASE_BLUE) begin
                partial = {8'h00, b};
                phase = PHASE_GREEN;
                return;
            end
            if (phase == PHASE_GREEN) begin
                partial[15:8] = b;
                phase = PHASE_RED;
                return;
            end
            phase = PHASE_BLUE;
            color = {b, partial};
            w = clamp_dim(width_reg);
            h = clamp_dim(height_reg);
            last_col = int'(col) + 1 >= int'(w);
            eoi = last_col && (int'(row) + 1 >= int'(h));
            vis = color != key;
            px.pixel_x = org_x + {4'h0, col};
            px.pixel_y = org_y + {4'h0, h} - {4'h0, row} - 16'd1;
            px.pixel_color = color;
            px.visible = vis;
            px.end_of_image = eoi;
            if (last_col) begin
                col = '0;
                row_bytes = 14'(w) * 14'd3;
                if (row_bytes[1:0] != 2'd0) begin
                    pad_left = 2'd0 - row_bytes[1:0];
                    in_pad = 1'b1;
                end else begin
                    advance_row();
                end
            end else begin
                col = col + 12'd1;
            end
            if (eoi) images_done++;
            if (eoi && !vis) hidden_finals++;
            if (vis || eoi) expected_q.push_back(px);
        endfunction

        task report_mismatch(input string msg);
            $display("[%0t] MISMATCH: %s", $time, msg);
            errors++;
        endtask

        task check_pixel(input t_pixel got);
            t_pixel want;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected pixel beat x=%0h y=%0h color=%0h",
                                          got.pixel_x, got.pixel_y, got.pixel_color));
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.pixel_x !== want.pixel_x)
                report_mismatch($sformatf("pixel_x %0h, want %0h", got.pixel_x, want.pixel_x));
            if (got.pixel_y !== want.pixel_y)
                report_mismatch($sformatf("pixel_y %0h, want %0h", got.pixel_y, want.pixel_y));
            if (got.pixel_color !== want.pixel_color)
                report_mismatch($sformatf("pixel_color %0h, want %0h",
                                          got.pixel_color, want.pixel_color));
            if (got.visible !== want.visible)
                report_mismatch($sformatf("visible %0b, want %0b", got.visible, want.visible));
            if (got.end_of_image !== want.end_of_image)
                report_mismatch($sformatf("end_of_image %0b, want %0b",
                                          got.end_of_image, want.end_of_image));
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    bmp24_in_if  pix_in();
    bmp24_out_if pix_out();

    pixel_scoreboard sb = new();

    int          burst_left = 0;
    bit          gaps_on = 1'b1;
    bit          long_hold_req = 1'b0;
    int          hold_count = 0;
    int          bytes_sent = 0;
    int          settings_used = 0;
    logic [23:0] pixel_plan = '0;

    bmp24_pixel_stream_unpacker_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_in),
        .o_pix   (pix_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #5000000;
        $display("Simulation FAILED");
        $finish;
    end

    // Receiver pacing: segments of always-ready, random stalls and a fixed duty cycle, plus a long hold-off on request
    initial begin : sink_pacing
        int seg_left;
        int seg_mode;
        int tick;
        seg_left = 0;
        seg_mode = 0;
        tick = 0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (long_hold_req) begin
                pix_out.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_count++;
                long_hold_req = 1'b0;
            end else begin
                if (seg_left == 0) begin
                    seg_mode = $urandom_range(0, 2);
                    seg_left = $urandom_range(40, 300);
                end
                seg_left--;
                case (seg_mode)
                    0:       pix_out.ready <= 1'b1;
                    1:       pix_out.ready <= ($urandom_range(0, 3) != 0);
                    default: pix_out.ready <= (tick % 5) < 2;
                endcase
            end
        end
    end

    // Output monitor
    always @(posedge i_clk) begin : pixel_monitor
        t_pixel got;
        if (i_rst_n === 1'b1 && pix_out.valid === 1'b1 && pix_out.ready === 1'b1) begin
            got.pixel_x = pix_out.pixel_x;
            got.pixel_y = pix_out.pixel_y;
            got.pixel_color = pix_out.pixel_color;
            got.visible = pix_out.visible;
            got.end_of_image = pix_out.end_of_image;
            sb.check_pixel(got);
        end
    end

    // Register write: setup cycle, then access cycle until pready
    task automatic apb_write(input logic [2:0] idx, input logic [31:0] v);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_reg(idx, v);
    endtask

    // One byte beat, preceded at the start of each burst by a random gap when gaps are on
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = gaps_on ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
                pix_in.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        pix_in.valid <= 1'b1;
        pix_in.data_byte <= b;
        do @(posedge i_clk); while (pix_in.ready !== 1'b1);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    // Stop sending, wait for every pending pixel, then let the pipe settle
    task automatic drain();
        pix_in.valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Next byte of a well-formed stream: padding is noise, pixels often hit the key
    function automatic logic [7:0] next_byte();
        logic [7:0] b;
        if (sb.in_pad) return 8'($urandom);
        case (sb.phase)
            PHASE_BLUE: begin
                case ($urandom_range(0, 9))
                    0, 1, 2: pixel_plan = sb.key;
                    3:       pixel_plan = 24'h000000;
                    4:       pixel_plan = 24'hFFFFFF;
                    default: pixel_plan = 24'($urandom);
                endcase
                b = pixel_plan[7:0];
            end
            PHASE_GREEN: b = pixel_plan[15:8];
            default:     b = pixel_plan[23:16];
        endcase
        return b;
    endfunction

    function automatic logic [11:0] pick_dim(input int small_max);
        case ($urandom_range(0, 9))
            0:       return 12'd0;
            1:       return MAX_DIM;
            2:       return 12'($urandom_range(1, 4095));
            default: return 12'($urandom_range(1, small_max));
        endcase
    endfunction

    function automatic logic [15:0] pick_origin();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(65500, 65535));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [23:0] pick_key();
        case ($urandom_range(0, 3))
            0:       return 24'h000000;
            1:       return 24'hFFFFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    // One register setting followed by a run of bytes
    task automatic run_phase(input int phase_no);
        int n_bytes;
        int w_eff;
        int h_eff;
        int stride;
        drain();
        if (phase_no == 0 || $urandom_range(0, 9) < 6)
            apb_write(REG_ORIGIN_X, 32'(pick_origin()));
        if (phase_no == 0 || $urandom_range(0, 9) < 6)
            apb_write(REG_ORIGIN_Y, 32'(pick_origin()));
        if (phase_no == 0 || $urandom_range(0, 9) < 6)
            apb_write(REG_IMAGE_WIDTH, 32'(pick_dim(6)));
        if (phase_no == 0 || $urandom_range(0, 9) < 6)
            apb_write(REG_IMAGE_HEIGHT, 32'(pick_dim(4)));
        if (phase_no == 0 || $urandom_range(0, 9) < 6)
            apb_write(REG_KEY_COLOR, 32'(pick_key()));
        settings_used++;
        w_eff = int'(sb.clamp_dim(sb.width_reg));
        h_eff = int'(sb.clamp_dim(sb.height_reg));
        if (w_eff <= 8 && h_eff <= 6) begin
            stride = ((3 * w_eff + 3) / 4) * 4;
            // whole images most of the time, else stop mid-image
            if ($urandom_range(0, 2) != 0) n_bytes = stride * h_eff * int'($urandom_range(1, 3));
            else n_bytes = $urandom_range(1, 60);
        end else begin
            n_bytes = $urandom_range(20, 90);
        end
        // long receiver hold-off while bytes keep coming
        if (phase_no % 9 == 2) begin
            long_hold_req = 1'b1;
            gaps_on = 1'b0;
            if (n_bytes < 48) n_bytes = 48;
        end else begin
            gaps_on = ($urandom_range(0, 3) != 0);
        end
        for (int i = 0; i < n_bytes; i++) send_byte(next_byte());
    endtask

    initial begin : stimulus
        logic [7:0] first_image [16];
        logic [7:0] tiny_image [4];
        int phase_no;
        first_image = '{8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hAA, 8'h55,
                        8'h56, 8'h34, 8'h12, 8'h56, 8'h34, 8'h12, 8'h55, 8'hAA};
        tiny_image = '{8'h01, 8'h7F, 8'h80, 8'hC3};
        phase_no = 0;

        i_rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        pix_in.valid <= 1'b0;
        pix_in.data_byte <= '0;
        pix_out.ready <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // 2x2 image at the far corner so both coordinates wrap; the top row is
        // all key color, so only its last pixel comes out, marked hidden
        apb_write(REG_ORIGIN_X, 32'h0000_FFFF);
        apb_write(REG_ORIGIN_Y, 32'h0000_FFFF);
        apb_write(REG_IMAGE_WIDTH, 32'd2);
        apb_write(REG_IMAGE_HEIGHT, 32'd2);
        apb_write(REG_KEY_COLOR, 32'h0012_3456);
        settings_used++;
        gaps_on = 1'b0;
        foreach (first_image[i]) send_byte(first_image[i]);
        drain();

        // zero width and height act as one; one padding byte per row
        apb_write(REG_ORIGIN_X, 32'd0);
        apb_write(REG_ORIGIN_Y, 32'd0);
        apb_write(REG_IMAGE_WIDTH, 32'd0);
        apb_write(REG_IMAGE_HEIGHT, 32'd0);
        settings_used++;
        foreach (tiny_image[i]) send_byte(tiny_image[i]);

        // random settings and streams
        while (bytes_sent < TARGET_BYTES) begin
            run_phase(phase_no);
            phase_no++;
        end

        drain();
        $display("Run covered %0d bitmap bytes under %0d register settings, %0d long hold-offs.",
                 bytes_sent, settings_used, hold_count);
        $display("Checked %0d pixel beats; %0d images completed, %0d with a hidden final pixel.",
                 sb.checked, sb.images_done, sb.hidden_finals);
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+sv
sv/bmp24_pkg.sv
sv/bmp24_in_if.sv
sv/bmp24_out_if.sv
sv/bmp24_pixel_stream_unpacker_top.sv
tb/bmp24_pixel_stream_unpacker_top_test.sv
